/* src/bglc_pkg.sv */
// Shared types, constants and arithmetic helpers of the battery gauge LED controller.
package bglc_pkg;

    localparam int LED_COUNT_DEF = 10;
    localparam int LED_FIELD_W   = 10;

    localparam logic [15:0] STEP_MS_RST   = 16'd100;
    localparam logic [15:0] HOLD_MS_RST   = 16'd3000;
    localparam logic [15:0] MANUAL_MS_RST = 16'd5000;

    localparam logic [9:0]  LOW_TENTHS    = 10'd100;
    localparam logic [9:0]  BLINK_TENTHS  = 10'd990;
    localparam logic [8:0]  CHG_HALF_MS   = 9'd250;
    localparam logic [10:0] LOW_HALF_MS   = 11'd1000;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_GAUGE    = 3'd1,
        MODE_LOW      = 3'd2,
        MODE_CHARGING = 3'd3,
        MODE_MANUAL   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        CFG_STEP   = 2'd0,
        CFG_HOLD   = 2'd1,
        CFG_MANUAL = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] step_ms;
        logic [15:0] hold_ms;
        logic [15:0] manual_window_ms;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  fill_index;
        logic [3:0]  fill_total;
        logic [31:0] step_stamp;
        t_mode       prev_mode;
    } t_gauge;

    // floor(t/100) for any 10-bit t: reciprocal 1311/2^17 is exact over this range
    function automatic logic [3:0] div100(input logic [9:0] t);
        logic [20:0] p;
        p = 21'(t) * 21'd1311;
        return p[20:17];
    endfunction

    // x mod 125, folding on 128 = 3 (mod 125)
    function automatic logic [6:0] mod125(input logic [29:0] x);
        logic [12:0] s;
        logic [7:0]  u;
        s = 13'(x[6:0]) + 13'(x[13:7]) * 13'd3 + 13'(x[20:14]) * 13'd9
          + 13'(x[27:21]) * 13'd27 + 13'(x[29:28]) * 13'd81;
        u = 8'(s[6:0]) + 8'(s[12:7]) * 8'd3;
        if (u >= 8'd125) u = u - 8'd125;
        if (u >= 8'd125) u = u - 8'd125;
        return u[6:0];
    endfunction

endpackage

/* src/battery_gauge_led_controller.sv */
// Top level of the battery gauge LED controller: handshake, registers and state.
//
// Accepts one evaluation item per clock and returns one result item for each:
// the item is captured in an input register, the mode choice and LED update
// run in one combinational pass against the stored LED and gauge state, and
// the result lands in an output register while the state is updated on the
// same edge. Sustained rate is one item per cycle as long as the result side
// takes items; a stalled result holds the input register and the input side
// stalls only when both stages are full.
// Configuration writes take effect at the edge they are presented.
module battery_gauge_led_controller import bglc_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [31:0]            i_now_ms,
    input  logic [31:0]            i_manual_stamp_ms,
    input  logic                   i_show_request,
    input  logic                   i_charging,
    input  logic [9:0]             i_charge_tenths,
    input  logic [9:0]             i_manual_pattern,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [LED_FIELD_W-1:0] o_led_pattern,
    output logic [2:0]             o_mode
);

    localparam int         WIDE_W  = (LED_COUNT > LED_FIELD_W) ? LED_COUNT : LED_FIELD_W;
    localparam logic [3:0] TOP_MAX = 4'(LED_COUNT - 1);

    t_cfg                   r_cfg;
    t_gauge                 r_gauge;
    t_gauge                 n_gauge;
    logic [LED_COUNT-1:0]   r_led;
    logic [LED_COUNT-1:0]   n_led;
    t_mode                  n_mode;

    logic                   r_s1_valid;
    logic [31:0]            r_s1_now_ms;
    logic [31:0]            r_s1_manual_stamp_ms;
    logic                   r_s1_show_request;
    logic                   r_s1_charging;
    logic [9:0]             r_s1_charge_tenths;
    logic [9:0]             r_s1_manual_pattern;

    logic                   r_out_valid;
    logic [LED_FIELD_W-1:0] r_out_led;
    t_mode                  r_out_mode;

    logic                   adv;
    logic                   in_take;
    logic [WIDE_W-1:0]      led_wide;

    assign adv        = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;
    assign led_wide   = WIDE_W'(n_led);

    assign o_out_valid   = r_out_valid;
    assign o_led_pattern = r_out_led;
    assign o_mode        = r_out_mode;

    bglc_eval #(
        .LED_COUNT(LED_COUNT)
    ) u_eval (
        .i_cfg             (r_cfg),
        .i_gauge           (r_gauge),
        .i_led             (r_led),
        .i_now_ms          (r_s1_now_ms),
        .i_manual_stamp_ms (r_s1_manual_stamp_ms),
        .i_show_request    (r_s1_show_request),
        .i_charging        (r_s1_charging),
        .i_charge_tenths   (r_s1_charge_tenths),
        .i_manual_pattern  (r_s1_manual_pattern),
        .o_gauge           (n_gauge),
        .o_led             (n_led),
        .o_mode            (n_mode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_ms          <= STEP_MS_RST;
            r_cfg.hold_ms          <= HOLD_MS_RST;
            r_cfg.manual_window_ms <= MANUAL_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STEP:   r_cfg.step_ms          <= i_cfg_data;
                CFG_HOLD:   r_cfg.hold_ms          <= i_cfg_data;
                CFG_MANUAL: r_cfg.manual_window_ms <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_now_ms          <= i_now_ms;
            r_s1_manual_stamp_ms <= i_manual_stamp_ms;
            r_s1_show_request    <= i_show_request;
            r_s1_charging        <= i_charging;
            r_s1_charge_tenths   <= i_charge_tenths;
            r_s1_manual_pattern  <= i_manual_pattern;
        end
    end

    // state moves with the item into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led                <= '0;
            r_gauge.fill_index   <= 4'd0;
            r_gauge.fill_total   <= 4'd0;
            r_gauge.step_stamp   <= 32'd0;
            r_gauge.prev_mode    <= MODE_NORMAL;
            r_out_valid          <= 1'b0;
        end else begin
            if (adv) begin
                r_led   <= n_led;
                r_gauge <= n_gauge;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_led  <= led_wide[LED_FIELD_W-1:0];
            r_out_mode <= n_mode;
        end
    end

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty input register");

    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out_valid)
        else $error("evaluated item did not reach the result register");

    a_low_only_led0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mode == MODE_LOW) |-> (o_led_pattern[LED_FIELD_W-1:1] == '0))
        else $error("low battery result lights LEDs above LED0");

    a_fill_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gauge.fill_total <= TOP_MAX)
        else $error("gauge fill total beyond last LED");

endmodule

/* src/bglc_eval.sv */
// Mode choice and next LED / gauge state for one evaluation.
module bglc_eval import bglc_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  t_cfg                 i_cfg,
    input  t_gauge               i_gauge,
    input  logic [LED_COUNT-1:0] i_led,
    input  logic [31:0]          i_now_ms,
    input  logic [31:0]          i_manual_stamp_ms,
    input  logic                 i_show_request,
    input  logic                 i_charging,
    input  logic [9:0]           i_charge_tenths,
    input  logic [9:0]           i_manual_pattern,
    output t_gauge               o_gauge,
    output logic [LED_COUNT-1:0] o_led,
    output t_mode                o_mode
);

    localparam logic [3:0] TOP_MAX = 4'(LED_COUNT - 1);
    localparam int PAT_W = (LED_COUNT > LED_FIELD_W) ? LED_COUNT : LED_FIELD_W;

    logic [31:0]          manual_age;
    logic [31:0]          step_age;
    logic                 manual_on;
    logic [3:0]           top;
    logic [3:0]           top_m1;
    logic [8:0]           m500;
    logic [10:0]          m2000;
    logic                 chg_blink_on;
    logic                 low_on;
    logic [LED_COUNT-1:0] lit_mask;
    logic [LED_COUNT-1:0] top_hot;
    logic [LED_COUNT-1:0] top_m1_hot;
    logic [LED_COUNT-1:0] fill_hot;
    logic [PAT_W-1:0]     pat_wide;

    assign manual_age   = i_now_ms - i_manual_stamp_ms;
    assign step_age     = i_now_ms - i_gauge.step_stamp;
    assign manual_on    = manual_age < {16'd0, i_cfg.manual_window_ms};
    assign top          = div100(i_charge_tenths);
    assign top_m1       = top - 4'd1;
    // now mod 500 and now mod 2000 built from a mod-125 fold of the upper bits
    assign m500         = {mod125(i_now_ms[31:2]), i_now_ms[1:0]};
    assign m2000        = {mod125({2'b00, i_now_ms[31:4]}), i_now_ms[3:0]};
    assign chg_blink_on = m500 < CHG_HALF_MS;
    assign low_on       = m2000 < LOW_HALF_MS;
    assign pat_wide     = PAT_W'(i_manual_pattern);

    always_comb begin
        for (int i = 0; i < LED_COUNT; i++) begin
            lit_mask[i]   = 11'(i * 100) < {1'b0, i_charge_tenths};
            top_hot[i]    = top == 4'(i);
            top_m1_hot[i] = top_m1 == 4'(i);
            fill_hot[i]   = i_gauge.fill_index == 4'(i);
        end
    end

    always_comb begin
        o_mode = MODE_NORMAL;
        if (i_show_request || i_gauge.prev_mode == MODE_GAUGE) o_mode = MODE_GAUGE;
        if (i_charge_tenths < LOW_TENTHS) o_mode = MODE_LOW;
        if (i_charging) o_mode = MODE_CHARGING;
        if (manual_on) o_mode = MODE_MANUAL;

        o_gauge = i_gauge;
        o_led   = i_led;

        case (o_mode)
            MODE_GAUGE: begin
                o_gauge.prev_mode = MODE_GAUGE;
                if (i_gauge.prev_mode != MODE_GAUGE) begin
                    o_gauge.fill_index = 4'd0;
                    o_gauge.fill_total = (top > TOP_MAX) ? TOP_MAX : top;
                    o_gauge.step_stamp = i_now_ms;
                end else if (i_gauge.fill_index <= i_gauge.fill_total) begin
                    if (step_age > {16'd0, i_cfg.step_ms}) begin
                        o_led              = i_led | fill_hot;
                        o_gauge.fill_index = i_gauge.fill_index + 4'd1;
                        o_gauge.step_stamp = i_now_ms;
                    end
                end else if (step_age > {16'd0, i_cfg.hold_ms}) begin
                    // hold over: clear, mode still reports gauge for this item
                    o_led             = '0;
                    o_gauge.prev_mode = MODE_NORMAL;
                end
            end
            MODE_MANUAL: begin
                o_led             = pat_wide[LED_COUNT-1:0];
                o_gauge.prev_mode = MODE_MANUAL;
            end
            MODE_NORMAL: begin
                o_led             = '0;
                o_gauge.prev_mode = MODE_NORMAL;
            end
            MODE_CHARGING: begin
                o_led = i_led | lit_mask;
                if (i_charge_tenths != 10'd0 && i_charge_tenths < BLINK_TENTHS) begin
                    if (chg_blink_on) o_led = o_led | top_hot;
                    else              o_led = o_led & ~top_hot;
                end else if (top != 4'd0) begin
                    o_led = o_led | top_m1_hot;
                end
                o_gauge.prev_mode = MODE_CHARGING;
            end
            default: begin
                o_led             = '0;
                o_led[0]          = low_on;
                o_gauge.prev_mode = MODE_LOW;
            end
        endcase
    end

endmodule

/* test/tb_battery_gauge_led_controller.sv */
// Self-checking testbench for the battery gauge LED controller.
module tb_battery_gauge_led_controller import bglc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LED_N       = LED_COUNT_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [31:0] now_ms;
        logic [31:0] stamp_ms;
        logic        show;
        logic        chg;
        logic [9:0]  tenths;
        logic [9:0]  pattern;
    } t_eval_item;

    typedef struct {
        logic [LED_FIELD_W-1:0] led;
        t_mode                  mode;
    } t_led_result;

    typedef enum {SC_GAUGE, SC_CHARGE, SC_LOW, SC_MANUAL, SC_NOISE} t_scene;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [1:0]             cfg_index = CFG_STEP;
    logic [15:0]            cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [31:0]            now_ms = '0;
    logic [31:0]            manual_stamp_ms = '0;
    logic                   show_request = 1'b0;
    logic                   charging = 1'b0;
    logic [9:0]             charge_tenths = '0;
    logic [9:0]             manual_pattern = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [LED_FIELD_W-1:0] led_pattern;
    logic [2:0]             mode_out;

    // predictor copy of the registers and state
    logic [15:0]            step_ms_r   = STEP_MS_RST;
    logic [15:0]            hold_ms_r   = HOLD_MS_RST;
    logic [15:0]            window_ms_r = MANUAL_MS_RST;
    logic [LED_FIELD_W-1:0] led_now     = '0;
    t_mode                  gauge_prev  = MODE_NORMAL;
    logic [3:0]             fill_idx    = '0;
    logic [3:0]             fill_total  = '0;
    logic [31:0]            gauge_stamp = '0;

    t_led_result pending_leds[$];
    int          mismatches  = 0;
    int          items_sent  = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_left   = 0;
    int          cycle_count = 0;

    battery_gauge_led_controller dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_now_ms          (now_ms),
        .i_manual_stamp_ms (manual_stamp_ms),
        .i_show_request    (show_request),
        .i_charging        (charging),
        .i_charge_tenths   (charge_tenths),
        .i_manual_pattern  (manual_pattern),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_led_pattern     (led_pattern),
        .o_mode            (mode_out)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // indexes past the bank are dropped
    function automatic void set_led(input int idx, input bit on);
        if (idx < LED_N) begin
            led_now[idx] = on;
        end
    endfunction

    function automatic t_led_result predict_leds(input t_eval_item it);
        t_mode       m;
        logic [31:0] since_manual;
        logic [31:0] since_step;
        logic [3:0]  top;
        t_led_result r;
        m = MODE_NORMAL;
        if (it.show || gauge_prev == MODE_GAUGE) m = MODE_GAUGE;
        if (it.tenths < 10'd100) m = MODE_LOW;
        if (it.chg) m = MODE_CHARGING;
        since_manual = it.now_ms - it.stamp_ms;
        if (since_manual < {16'd0, window_ms_r}) m = MODE_MANUAL;
        since_step = it.now_ms - gauge_stamp;
        top = 4'(it.tenths / 10'd100);
        case (m)
            MODE_GAUGE: begin
                if (gauge_prev != MODE_GAUGE) begin
                    fill_idx    = '0;
                    fill_total  = (top > 4'(LED_N - 1)) ? 4'(LED_N - 1) : top;
                    gauge_stamp = it.now_ms;
                    gauge_prev  = MODE_GAUGE;
                end else if (fill_idx <= fill_total) begin
                    if (since_step > {16'd0, step_ms_r}) begin
                        set_led(fill_idx, 1'b1);
                        fill_idx    = fill_idx + 4'd1;
                        gauge_stamp = it.now_ms;
                    end
                end else if (since_step > {16'd0, hold_ms_r}) begin
                    // hold over: clear, but this item still reports gauge
                    led_now    = '0;
                    gauge_prev = MODE_NORMAL;
                end
            end
            MODE_MANUAL: begin
                led_now    = it.pattern;
                gauge_prev = MODE_MANUAL;
            end
            MODE_NORMAL: begin
                led_now    = '0;
                gauge_prev = MODE_NORMAL;
            end
            MODE_CHARGING: begin
                for (int i = 0; i < LED_N; i++) begin
                    if (i * 100 < int'(it.tenths)) set_led(i, 1'b1);
                end
                if (it.tenths > 10'd0 && it.tenths < 10'd990) begin
                    set_led(top, (it.now_ms % 32'd500) < 32'd250);
                end else if (top > 4'd0) begin
                    set_led(top - 4'd1, 1'b1);
                end
                gauge_prev = MODE_CHARGING;
            end
            default: begin
                for (int i = 1; i < LED_N; i++) set_led(i, 1'b0);
                set_led(0, (it.now_ms % 32'd2000) < 32'd1000);
                gauge_prev = MODE_LOW;
            end
        endcase
        r.led  = led_now;
        r.mode = m;
        return r;
    endfunction

    // result side: random stalls, or a counted hold-off when requested
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall = ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk) begin : check_results
        t_led_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_leds.size() == 0) begin
                $display("%0t: unexpected item led=%b mode=%0d", $time, led_pattern, mode_out);
                mismatches++;
            end else begin
                want = pending_leds.pop_front();
                if (want.led !== led_pattern) begin
                    $display("%0t: led_pattern expected %b, actual %b",
                             $time, want.led, led_pattern);
                    mismatches++;
                end
                if (want.mode !== mode_out) begin
                    $display("%0t: mode expected %0d, actual %0d",
                             $time, want.mode, mode_out);
                    mismatches++;
                end
            end
        end
    end

    // all tasks below start and end just after a falling edge
    task automatic offer_eval(input t_eval_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        now_ms          = it.now_ms;
        manual_stamp_ms = it.stamp_ms;
        show_request    = it.show;
        charging        = it.chg;
        charge_tenths   = it.tenths;
        manual_pattern  = it.pattern;
        in_valid        = 1'b1;
        do @(posedge clk); while (in_stall);
        pending_leds.push_back(predict_leds(it));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic settle_pipeline();
        in_valid = 1'b0;
        while (pending_leds.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_regs(input logic [15:0] s, input logic [15:0] h,
                                input logic [15:0] w);
        settle_pipeline();
        cfg_we    = 1'b1;
        cfg_index = CFG_STEP;
        cfg_data  = s;
        @(negedge clk);
        cfg_index = CFG_HOLD;
        cfg_data  = h;
        @(negedge clk);
        cfg_index = CFG_MANUAL;
        cfg_data  = w;
        @(negedge clk);
        cfg_we      = 1'b0;
        step_ms_r   = s;
        hold_ms_r   = h;
        window_ms_r = w;
    endtask

    function automatic t_eval_item eval_item(input logic [31:0] now, input logic [31:0] stamp,
                                             input bit show, input bit chg,
                                             input logic [9:0] t, input logic [9:0] pat);
        t_eval_item it;
        it.now_ms   = now;
        it.stamp_ms = stamp;
        it.show     = show;
        it.chg      = chg;
        it.tenths   = t;
        it.pattern  = pat;
        return it;
    endfunction

    function automatic logic [15:0] pick_reg_value(input int cap);
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'd0;
        if (r < 20) return 16'hFFFF;
        return 16'($urandom_range(cap));
    endfunction

    task automatic run_scenario(input t_scene kind, input int len);
        t_eval_item  it;
        logic [31:0] now;
        logic [31:0] man_stamp;
        logic [9:0]  t;
        case ($urandom_range(3))
            0: now = $urandom;
            1: now = 32'hFFFF_FFFF - $urandom_range(20000);
            default: now = $urandom_range(1000000);
        endcase
        man_stamp = now;
        t = 10'($urandom_range(100, 1023));
        for (int k = 0; k < len; k++) begin
            it = eval_item(now, now + 32'd1 + $urandom_range(1000), 1'b0, 1'b0, t,
                           10'($urandom));
            case (kind)
                SC_GAUGE: begin
                    it.show = (k == 0) || ($urandom_range(99) < 8);
                    // occasional breaks: low charge, charger plugged, manual command
                    if ($urandom_range(99) < 4) it.tenths = 10'($urandom_range(1023));
                    if ($urandom_range(99) < 3) it.chg = 1'b1;
                    if ($urandom_range(99) < 3)
                        it.stamp_ms = now - $urandom_range(int'(window_ms_r));
                end
                SC_CHARGE: begin
                    it.chg  = 1'b1;
                    it.show = 1'($urandom_range(1));
                    if ($urandom_range(99) < 70) it.tenths = 10'($urandom_range(1023));
                end
                SC_LOW: begin
                    it.show   = 1'($urandom_range(1));
                    it.tenths = 10'($urandom_range(99));
                end
                SC_MANUAL: begin
                    it.stamp_ms = man_stamp;
                    it.show     = 1'($urandom_range(1));
                    it.chg      = 1'($urandom_range(1));
                    it.tenths   = 10'($urandom_range(1023));
                end
                default: begin
                    it = eval_item($urandom, $urandom, 1'($urandom_range(1)),
                                   1'($urandom_range(1)),
                                   10'($urandom_range(1023)), 10'($urandom));
                    if ($urandom_range(1))
                        it.stamp_ms = it.now_ms - $urandom_range(2 * int'(window_ms_r) + 1);
                end
            endcase
            offer_eval(it);
            case (kind)
                SC_GAUGE: begin
                    if ($urandom_range(99) < 70)
                        now += $urandom_range(2 * int'(step_ms_r) + 2);
                    else
                        now += $urandom_range(int'(hold_ms_r) + int'(hold_ms_r) / 4 + 2);
                end
                SC_CHARGE: now += $urandom_range(700);
                SC_LOW:    now += $urandom_range(2500);
                SC_MANUAL: now += $urandom_range(int'(window_ms_r) / 3 + 2);
                default:   now = $urandom;
            endcase
        end
    endtask

    // reset register values: every mode, blink phases, charge edges,
    // manual window edge and wrap, a gauge run across the time wrap
    task automatic test_directed_modes();
        logic [31:0] n;
        logic [31:0] g;
        n = 32'd100000;
        g = 32'hFFFF_FFC0;
        offer_eval(eval_item(n, n + 1, 0, 0, 10'd500, 10'd0));
        offer_eval(eval_item(n, n + 1, 0, 0, 10'd0, 10'h3FF));
        offer_eval(eval_item(n + 1500, n + 1501, 0, 0, 10'd99, 10'd0));
        offer_eval(eval_item(n + 1500, n + 1501, 0, 1, 10'd0, 10'd0));
        offer_eval(eval_item(n, n + 1, 0, 1, 10'd1, 10'd0));
        offer_eval(eval_item(n + 250, n + 251, 0, 1, 10'd989, 10'd0));
        offer_eval(eval_item(n + 250, n + 251, 0, 1, 10'd990, 10'd0));
        offer_eval(eval_item(n, n + 1, 1, 1, 10'd1023, 10'd0));
        offer_eval(eval_item(n, n, 0, 0, 10'd500, 10'h3FF));
        offer_eval(eval_item(n, n - 4999, 0, 0, 10'd500, 10'h155));
        offer_eval(eval_item(n, n - 5000, 0, 0, 10'd500, 10'h155));
        offer_eval(eval_item(32'd5, 32'hFFFF_FFFF, 0, 0, 10'd500, 10'h2AA));
        offer_eval(eval_item(g, g + 1, 1, 0, 10'd250, 10'd0));
        offer_eval(eval_item(g + 100, g + 101, 0, 0, 10'd250, 10'd0));
        offer_eval(eval_item(g + 201, g + 202, 0, 0, 10'd250, 10'd0));
        offer_eval(eval_item(g + 302, g + 303, 0, 0, 10'd250, 10'd0));
        offer_eval(eval_item(g + 403, g + 404, 0, 0, 10'd250, 10'd0));
        offer_eval(eval_item(g + 3403, g + 3404, 0, 0, 10'd250, 10'd0));
        offer_eval(eval_item(g + 3404, g + 3405, 0, 0, 10'd250, 10'd0));
        offer_eval(eval_item(g + 3409, g + 3410, 0, 0, 10'd250, 10'd0));
        offer_eval(eval_item(n, n + 1, 1, 0, 10'd1023, 10'd0));
        offer_eval(eval_item(n + 10, n + 11, 0, 0, 10'd50, 10'd0));
    endtask

    task automatic test_register_extremes();
        logic [15:0] steps[4] = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFF};
        logic [15:0] holds[4] = '{16'd0, 16'hFFFF, 16'd0, 16'd1};
        logic [15:0] wins[4]  = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd1};
        for (int s = 0; s < 4; s++) begin
            program_regs(steps[s], holds[s], wins[s]);
            run_scenario(SC_GAUGE, 25);
            run_scenario(SC_MANUAL, 8);
            run_scenario(SC_CHARGE, 6);
            run_scenario(SC_NOISE, 4);
        end
    endtask

    // long result hold-off with the input kept busy, then a full drain
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(16'd20, 16'd200, 16'd1000);
        hold_left = 300;
        run_scenario(SC_GAUGE, 40);
        settle_pipeline();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int     target;
        int     scenes;
        int     r;
        t_scene kind;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = items_sent + count;
        scenes = 0;
        while (items_sent < target) begin
            if (scenes % 10 == 0)
                program_regs(pick_reg_value(300), pick_reg_value(1000), pick_reg_value(3000));
            r = $urandom_range(99);
            if (r < 35) kind = SC_GAUGE;
            else if (r < 55) kind = SC_CHARGE;
            else if (r < 68) kind = SC_LOW;
            else if (r < 83) kind = SC_MANUAL;
            else kind = SC_NOISE;
            run_scenario(kind, (kind == SC_GAUGE) ? $urandom_range(12, 45)
                                                  : $urandom_range(3, 15));
            scenes++;
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_modes();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic(22, 61, 470);
        test_random_traffic(61, 22, 470);
        test_random_traffic(0, 0, 470);
        settle_pipeline();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
